@@ hw/rtl/xte_pkg.sv @@
package xte_pkg;

    // Plain characters that map to named entities
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    // UTF-8 bytes of the recognized sequences
    localparam logic [7:0] LEAD_TWO   = 8'hC2;
    localparam logic [7:0] LEAD_THREE = 8'hE2;
    localparam logic [7:0] MID_THREE  = 8'h82;
    localparam logic [7:0] TRAIL_COPY = 8'hA9;
    localparam logic [7:0] TRAIL_REG  = 8'hAE;
    localparam logic [7:0] TRAIL_EURO = 8'hAC;

    // Held-prefix counts
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_LEAD = 2'd1;
    localparam logic [1:0] HOLD_MID  = 2'd2;

    localparam int RUN_MAX = 8;

    // Entity texts, element 0 goes out first
    localparam logic [7:0][7:0] ENT_AMP  =
        {8'h00, 8'h00, 8'h00, ";", "p", "m", "a", "&"};
    localparam logic [7:0][7:0] ENT_LT   =
        {8'h00, 8'h00, 8'h00, 8'h00, ";", "t", "l", "&"};
    localparam logic [7:0][7:0] ENT_GT   =
        {8'h00, 8'h00, 8'h00, 8'h00, ";", "t", "g", "&"};
    localparam logic [7:0][7:0] ENT_QUOT =
        {8'h00, 8'h00, ";", "t", "o", "u", "q", "&"};
    localparam logic [7:0][7:0] ENT_APOS =
        {8'h00, 8'h00, ";", "s", "o", "p", "a", "&"};
    localparam logic [7:0][7:0] ENT_COPY =
        {8'h00, 8'h00, ";", "9", "6", "1", "#", "&"};
    localparam logic [7:0][7:0] ENT_REG  =
        {8'h00, 8'h00, ";", "4", "7", "1", "#", "&"};
    localparam logic [7:0][7:0] ENT_EURO =
        {8'h00, ";", "4", "6", "3", "8", "#", "&"};

    // Prefix held back between input transactions
    typedef struct packed {
        logic [1:0] cnt;
        logic       three;
    } t_hold;

    // Bytes produced by one input transaction
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      len;
    } t_run;

endpackage

@@ hw/rtl/xte_in_if.sv @@
interface xte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;

    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

@@ hw/rtl/xte_out_if.sv @@
interface xte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_done;
    logic       text_done;

    modport source (output valid, output out_byte, output run_done, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_done, input text_done,
                    output ready);
endinterface

@@ hw/rtl/xte_expand.sv @@
module xte_expand (
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    input  xte_pkg::t_hold i_hold,
    output xte_pkg::t_run  o_run,
    output xte_pkg::t_hold o_hold
);
    import xte_pkg::*;

    logic [7:0][7:0] fr_bytes;
    logic [2:0]      fr_len;
    logic            fr_hold;
    logic            fr_three;
    logic [1:0][7:0] pre_bytes;
    logic [1:0]      pre_len;
    logic            use_fresh;
    logic            direct;
    logic [7:0][7:0] direct_bytes;
    logic [2:0]      direct_len;
    logic [2:0]      j;

    // Current byte with nothing held
    always_comb begin
        fr_bytes = {8{8'h00}};
        fr_len   = 3'd1;
        fr_hold  = 1'b0;
        fr_three = 1'b0;
        case (i_byte)
            CH_AMP: begin
                fr_bytes = ENT_AMP;
                fr_len   = 3'd5;
            end
            CH_LT: begin
                fr_bytes = ENT_LT;
                fr_len   = 3'd4;
            end
            CH_GT: begin
                fr_bytes = ENT_GT;
                fr_len   = 3'd4;
            end
            CH_QUOT: begin
                fr_bytes = ENT_QUOT;
                fr_len   = 3'd6;
            end
            CH_APOS: begin
                fr_bytes = ENT_APOS;
                fr_len   = 3'd6;
            end
            default: begin
                fr_bytes[0] = i_byte;
                if ((i_byte inside {LEAD_TWO, LEAD_THREE}) && !i_end) begin
                    fr_len   = 3'd0;
                    fr_hold  = 1'b1;
                    fr_three = (i_byte == LEAD_THREE);
                end
            end
        endcase
    end

    // Held prefix: match, keep holding, or flush raw
    always_comb begin
        pre_bytes    = {2{8'h00}};
        pre_len      = 2'd0;
        use_fresh    = 1'b1;
        direct       = 1'b0;
        direct_bytes = ENT_EURO;
        direct_len   = 3'd7;
        o_hold       = '0;
        if (i_hold.cnt == HOLD_NONE) begin
            use_fresh = 1'b1;
        end else if (i_hold.cnt == HOLD_LEAD && !i_hold.three) begin
            if (i_byte == TRAIL_COPY) begin
                use_fresh    = 1'b0;
                direct       = 1'b1;
                direct_bytes = ENT_COPY;
                direct_len   = 3'd6;
            end else if (i_byte == TRAIL_REG) begin
                use_fresh    = 1'b0;
                direct       = 1'b1;
                direct_bytes = ENT_REG;
                direct_len   = 3'd6;
            end else begin
                pre_bytes[0] = LEAD_TWO;
                pre_len      = 2'd1;
            end
        end else if (i_hold.cnt == HOLD_LEAD) begin
            if (i_byte == MID_THREE) begin
                use_fresh = 1'b0;
                if (i_end) begin
                    pre_bytes = {MID_THREE, LEAD_THREE};
                    pre_len   = 2'd2;
                end else begin
                    o_hold.cnt   = HOLD_MID;
                    o_hold.three = 1'b1;
                end
            end else begin
                pre_bytes[0] = LEAD_THREE;
                pre_len      = 2'd1;
            end
        end else begin
            // E2 82 held; an unreachable count of three lands here too
            if (i_byte == TRAIL_EURO) begin
                use_fresh = 1'b0;
                direct    = 1'b1;
            end else begin
                pre_bytes = {MID_THREE, LEAD_THREE};
                pre_len   = 2'd2;
            end
        end
        if (use_fresh && fr_hold) begin
            o_hold.cnt   = HOLD_LEAD;
            o_hold.three = fr_three;
        end
        if (i_end) begin
            o_hold = '0;
        end
    end

    // Splice raw prefix ahead of the fresh byte's output
    always_comb begin
        o_run.bytes = {8{8'h00}};
        o_run.len   = 4'd0;
        j           = 3'd0;
        if (direct) begin
            o_run.bytes = direct_bytes;
            o_run.len   = {1'b0, direct_len};
        end else begin
            for (int k = 0; k < RUN_MAX; k++) begin
                j = 3'(k) - {1'b0, pre_len};
                if (k < 32'(pre_len)) begin
                    o_run.bytes[k] = pre_bytes[k[0]];
                end else begin
                    o_run.bytes[k] = fr_bytes[j];
                end
            end
            o_run.len = {2'b00, pre_len} + (use_fresh ? {1'b0, fr_len} : 4'd0);
        end
    end

endmodule

@@ hw/rtl/xml_text_escaper_top.sv @@
// Channel  | Dir | Payload                          | Transaction
// i_in     | in  | in_byte[7:0], in_end             | valid & ready
// o_out    | out | out_byte[7:0], run_done, text_done | valid & ready
//
// Each input byte is expanded in the cycle it is taken and its run (0 to 8
// bytes) is registered; results appear the cycle after acceptance.
// A plain byte passes through unchanged; an entity run holds the input until its
// last byte leaves the output register, which sends the run's bytes in order. A
// held lead byte is taken and gives no result, so nothing is loaded into the run.
// Input is taken while the last byte of the current run leaves, so plain text
// streams at one byte per cycle under no stall. i_rst_n (synchronous, active
// low) empties the run register and drops any held prefix.
module xml_text_escaper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xte_in_if.sink     i_in,
    xte_out_if.source  o_out
);
    import xte_pkg::*;

    t_hold           r_hold;
    t_hold           n_hold;
    t_run            n_run;
    logic [7:0][7:0] r_bytes;
    logic [3:0]      r_rem;
    logic [2:0]      r_pos;
    logic            r_end;
    logic            in_acc;
    logic            out_acc;
    logic            load;

    xte_expand u_expand (
        .i_byte (i_in.in_byte),
        .i_end  (i_in.in_end),
        .i_hold (r_hold),
        .o_run  (n_run),
        .o_hold (n_hold)
    );

    // Handshakes: take input while the run register is empty or empties this cycle
    assign out_acc    = o_out.valid && o_out.ready;
    assign i_in.ready = (r_rem == 4'd0) || (r_rem == 4'd1 && o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign load       = in_acc && (n_run.len != 4'd0);

    // Output from the run register
    assign o_out.valid     = (r_rem != 4'd0);
    assign o_out.out_byte  = r_bytes[r_pos];
    assign o_out.run_done  = (r_rem == 4'd1);
    assign o_out.text_done = (r_rem == 4'd1) && r_end;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_rem  <= 4'd0;
            r_pos  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_hold <= n_hold;
            end
            if (load) begin
                r_rem <= n_run.len;
                r_pos <= 3'd0;
            end else if (out_acc) begin
                r_rem <= r_rem - 4'd1;
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    // Run payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_run.bytes;
            r_end   <= i_in.in_end;
        end
    end

    // A string's end leaves nothing held
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.in_end |=> r_hold == '0)
        else $error("held prefix survives end of string");

    // Held count stays below three
    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold.cnt != 2'd3)
        else $error("held count out of range");

    // Run length never exceeds eight
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 4'd8)
        else $error("run length out of range");

    // Last byte of a run leaves with no new run behind it: output goes idle
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out.run_done && !load |=> !o_out.valid)
        else $error("output valid after run drained");

    // Text end is only flagged on a run's last byte
    a_text_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.text_done |-> o_out.run_done)
        else $error("text end without run end");

endmodule
